// File: hdl/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg: shared types and constants of the HTML entity decoder
// Character codes, the table of known entity names and the control struct
// that travels with each burst of output bytes.
// ----------------------------------------------------------------------------
package hed_pkg;

	typedef logic [7:0] byte_t;

	localparam byte_t AMP_CHAR  = 8'h26;
	localparam byte_t SEMI_CHAR = 8'h3B;

	// Known entity names, first character at index 0
	localparam int unsigned ENT_NUM     = 6;
	localparam int unsigned ENT_MAX_LEN = 5;

	localparam byte_t ENT_TEXT [ENT_NUM][ENT_MAX_LEN] = '{
		'{"a", "m", "p", 8'h00, 8'h00},
		'{"g", "t", 8'h00, 8'h00, 8'h00},
		'{"l", "t", 8'h00, 8'h00, 8'h00},
		'{"n", "b", "s", "p", 8'h00},
		'{"p", "l", "u", "s", 8'h00},
		'{"q", "u", "e", "s", "t"}
	};
	localparam int unsigned ENT_LEN [ENT_NUM] = '{3, 2, 2, 4, 4, 5};
	localparam byte_t ENT_REPL [ENT_NUM] = '{8'h26, 8'h3E, 8'h3C, 8'h20, 8'h2B, 8'h3F};

	// Burst length field covers the largest supported name length (16 + 2)
	localparam int unsigned LEN_W = 5;

	typedef struct packed {
		logic [LEN_W-1:0] len;   // number of bytes in the burst, never zero
		logic             done;  // burst closes the text
	} burst_ctl_t;

endpackage

// File: hdl/hed_front.sv
// ----------------------------------------------------------------------------
// hed_front: entity scanner
// Takes one text byte per cycle unless q_full, tracks the held '&' and name
// bytes, and builds the complete burst of bytes that the byte releases.
// ----------------------------------------------------------------------------
module hed_front #(
	parameter int unsigned MAX_NAME = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  hed_pkg::byte_t                      in_byte,
	input  logic                                stream_end,
	input  logic                                q_full,
	output logic                                push,
	output hed_pkg::burst_ctl_t                 push_ctl,
	output logic [MAX_NAME+1:0][7:0]            push_data
);
	import hed_pkg::*;

	localparam int unsigned OUT_CAP = MAX_NAME + 2;
	localparam int unsigned CW      = $clog2(MAX_NAME + 1);
	localparam int unsigned JW      = $clog2(MAX_NAME + 2);

	logic                         ent_q;
	logic [CW-1:0]                cnt_q;
	logic [MAX_NAME-1:0][7:0]     buf_q;

	logic                         ne;
	logic [CW-1:0]                ncnt;
	logic [MAX_NAME-1:0][7:0]     nbuf;
	logic [MAX_NAME:0][7:0]       tmp;
	logic [(MAX_NAME+1)*8-1:0]    shr;
	logic [JW+2:0]                sh_amt;
	logic                         found;
	logic [JW-1:0]                amp_pos;
	logic                         hit;
	byte_t                        hit_byte;
	logic [OUT_CAP-1:0][7:0]      a_list;
	logic [LEN_W-1:0]             a_len;
	logic [OUT_CAP*8-1:0]         ext_w;
	logic [LEN_W+2:0]             ext_sh;
	logic                         accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Name lookup against the held bytes
	always_comb begin
		logic m;
		hit      = 1'b0;
		hit_byte = '0;
		for (int k = 0; k < ENT_NUM; k++) begin
			m = (ENT_LEN[k] <= MAX_NAME) && (cnt_q == CW'(ENT_LEN[k]));
			for (int i = 0; i < MAX_NAME; i++) begin
				if (i < ENT_LEN[k] && i < ENT_MAX_LEN) begin
					if (buf_q[i] != ENT_TEXT[k][i]) begin
						m = 1'b0;
					end
				end
			end
			if (m && !hit) begin
				hit      = 1'b1;
				hit_byte = ENT_REPL[k];
			end
		end
	end

	// Overflow rescan: held bytes plus the new byte, find the first '&'
	assign tmp = {in_byte, buf_q};

	always_comb begin
		found   = 1'b0;
		amp_pos = '0;
		for (int i = MAX_NAME; i >= 0; i--) begin
			if (tmp[i] == AMP_CHAR) begin
				found   = 1'b1;
				amp_pos = JW'(i);
			end
		end
	end

	assign sh_amt = {amp_pos + JW'(1), 3'b000};
	assign shr    = tmp >> sh_amt;

	// Burst assembly and next state
	always_comb begin
		a_list = '0;
		a_len  = '0;
		ne     = ent_q;
		ncnt   = cnt_q;
		nbuf   = buf_q;
		if (!ent_q) begin
			if (in_byte == AMP_CHAR) begin
				ne   = 1'b1;
				ncnt = '0;
			end else begin
				a_list[0] = in_byte;
				a_len     = LEN_W'(1);
			end
		end else if (in_byte == SEMI_CHAR) begin
			ne   = 1'b0;
			ncnt = '0;
			if (hit) begin
				a_list[0] = hit_byte;
				a_len     = LEN_W'(1);
			end else begin
				// unknown or empty name goes out as text
				a_list[0] = AMP_CHAR;
				for (int i = 0; i < MAX_NAME; i++) begin
					if (CW'(i) < cnt_q) begin
						a_list[i+1] = buf_q[i];
					end
				end
				for (int i = 1; i < OUT_CAP; i++) begin
					if (LEN_W'(i) == LEN_W'(cnt_q) + LEN_W'(1)) begin
						a_list[i] = SEMI_CHAR;
					end
				end
				a_len = LEN_W'(cnt_q) + LEN_W'(2);
			end
		end else if (cnt_q < CW'(MAX_NAME)) begin
			for (int i = 0; i < MAX_NAME; i++) begin
				if (cnt_q == CW'(i)) begin
					nbuf[i] = in_byte;
				end
			end
			ncnt = cnt_q + CW'(1);
		end else begin
			// name too long: release '&', rescan held bytes and the new one
			a_list[0] = AMP_CHAR;
			if (found) begin
				for (int i = 0; i <= MAX_NAME; i++) begin
					if (JW'(i) < amp_pos) begin
						a_list[i+1] = tmp[i];
					end
				end
				a_len = LEN_W'(amp_pos) + LEN_W'(1);
				ne    = 1'b1;
				ncnt  = CW'(MAX_NAME) - CW'(amp_pos);
				nbuf  = shr[MAX_NAME*8-1:0];
			end else begin
				for (int i = 0; i <= MAX_NAME; i++) begin
					a_list[i+1] = tmp[i];
				end
				a_len = LEN_W'(OUT_CAP);
				ne    = 1'b0;
				ncnt  = '0;
			end
		end
	end

	// End of text appends whatever is still held after the burst
	assign ext_w  = {8'h00, nbuf, AMP_CHAR};
	assign ext_sh = {a_len, 3'b000};

	always_comb begin
		push_data    = a_list;
		push_ctl.len = a_len;
		if (stream_end && ne) begin
			push_data    = a_list | (ext_w << ext_sh);
			push_ctl.len = a_len + LEN_W'(ncnt) + LEN_W'(1);
		end
		push_ctl.done = stream_end;
	end

	assign push = accept && (push_ctl.len != '0);

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= 1'b0;
			cnt_q <= '0;
			buf_q <= '0;
		end else if (accept) begin
			ent_q <= ne && !stream_end;
			cnt_q <= stream_end ? '0 : ncnt;
			buf_q <= nbuf;
		end
	end

endmodule

// File: hdl/hed_queue.sv
// ----------------------------------------------------------------------------
// hed_queue: burst queue
// Short first-in first-out store of complete bursts between the scanner and
// the output serializer.
// ----------------------------------------------------------------------------
module hed_queue #(
	parameter int unsigned DEPTH = 4,
	parameter int unsigned NB    = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  hed_pkg::burst_ctl_t      push_ctl,
	input  logic [NB-1:0][7:0]       push_data,
	input  logic                     pop,
	output hed_pkg::burst_ctl_t      head_ctl,
	output logic [NB-1:0][7:0]       head_data,
	output logic                     empty,
	output logic                     full
);
	import hed_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned FW = $clog2(DEPTH + 1);

	burst_ctl_t          ctl_q  [DEPTH];
	logic [NB-1:0][7:0]  data_q [DEPTH];
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [FW-1:0]       fill_q;
	logic                do_push;
	logic                do_pop;

	assign empty   = (fill_q == '0);
	assign full    = (fill_q == FW'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	assign head_ctl  = ctl_q[rd_ptr_q];
	assign head_data = data_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			ctl_q[wr_ptr_q]  <= push_ctl;
			data_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("burst pushed into a full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("burst popped from an empty queue");

	a_head_len: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (head_ctl.len != '0) && (head_ctl.len <= LEN_W'(NB)))
		else $error("queue head carries a bad burst length");

endmodule

// File: hdl/hed_back.sv
// ----------------------------------------------------------------------------
// hed_back: output serializer
// Walks the head burst one byte per cycle while out_stall is low into a
// registered output beat and pops the burst as its last byte is loaded.
// ----------------------------------------------------------------------------
module hed_back #(
	parameter int unsigned NB = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	input  hed_pkg::burst_ctl_t      head_ctl,
	input  logic [NB-1:0][7:0]       head_data,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output hed_pkg::byte_t           out_byte,
	output logic                     run_last,
	output logic                     text_done
);
	import hed_pkg::*;

	localparam int unsigned IW = $clog2(NB);

	logic [IW-1:0]  idx_q;
	logic           out_valid_q;
	byte_t          out_byte_q;
	logic           run_last_q;
	logic           text_done_q;
	logic           adv;
	logic           last;

	assign adv  = !out_valid_q || !out_stall;
	assign last = (LEN_W'(idx_q) + LEN_W'(1) == head_ctl.len);
	assign pop  = adv && !q_empty && last;

	// Control: beat valid and position in the burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (adv) begin
			out_valid_q <= !q_empty;
			if (!q_empty) begin
				idx_q <= last ? '0 : idx_q + IW'(1);
			end
		end
	end

	// Output beat payload
	always_ff @(posedge clk) begin
		if (adv && !q_empty) begin
			out_byte_q  <= head_data[idx_q];
			run_last_q  <= last;
			text_done_q <= last && head_ctl.done;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign text_done = text_done_q;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && text_done_q |-> run_last_q)
		else $error("text end flagged on a beat that does not close its burst");

	a_mid_burst_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> !q_empty)
		else $error("burst left the queue before its last byte");

	a_idx_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> LEN_W'(idx_q) < head_ctl.len)
		else $error("byte index ran past the burst length");

endmodule

// File: hdl/html_entity_decoder.sv
// ----------------------------------------------------------------------------
// html_entity_decoder: streaming HTML named entity decoder
// Replaces &amp; &gt; &lt; &nbsp; &plus; &quest; in a byte stream with their
// characters; other text, unknown names and over-long names pass unchanged.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  input   | in_valid / in_stall   | in_byte, stream_end
//  output  | out_valid / out_stall | out_byte, run_last, text_done
//
//  The scanner takes one input beat per cycle while the burst queue has room.
//  Each input beat yields 0 to MAX_NAME+2 output bytes; the serializer sends
//  one output beat per cycle while out_stall is low. An output byte is
//  registered first in the queue entry and then in the output register.
//  Reset clears scanner state, queue pointers, beat valid and index at once.
//  Input stall rises only when QUEUE_DEPTH bursts are waiting.
//
module html_entity_decoder #(
	parameter int unsigned MAX_NAME    = 5,
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  hed_pkg::byte_t  in_byte,
	input  logic            stream_end,
	output logic            out_valid,
	input  logic            out_stall,
	output hed_pkg::byte_t  out_byte,
	output logic            run_last,
	output logic            text_done
);
	import hed_pkg::*;

	localparam int unsigned OUT_CAP = MAX_NAME + 2;

	logic                      q_full;
	logic                      q_empty;
	logic                      push;
	logic                      pop;
	burst_ctl_t                push_ctl;
	burst_ctl_t                head_ctl;
	logic [OUT_CAP-1:0][7:0]   push_data;
	logic [OUT_CAP-1:0][7:0]   head_data;

	hed_front #(
		.MAX_NAME (MAX_NAME)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.stream_end (stream_end),
		.q_full     (q_full),
		.push       (push),
		.push_ctl   (push_ctl),
		.push_data  (push_data)
	);

	hed_queue #(
		.DEPTH (QUEUE_DEPTH),
		.NB    (OUT_CAP)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ctl  (push_ctl),
		.push_data (push_data),
		.pop       (pop),
		.head_ctl  (head_ctl),
		.head_data (head_data),
		.empty     (q_empty),
		.full      (q_full)
	);

	hed_back #(
		.NB (OUT_CAP)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head_ctl  (head_ctl),
		.head_data (head_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.text_done (text_done)
	);

endmodule
